// ----- hdl/indirect_rotate_prng_generator_core_defines.svh -----
// assertion macros for the indirect rotate generator
`ifndef INDIRECT_ROTATE_PRNG_GENERATOR_CORE_DEFINES_SVH
`define INDIRECT_ROTATE_PRNG_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IRPG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define IRPG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IRPG_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define IRPG_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hdl/irpg_pkg.sv -----
package irpg_pkg;

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 9;
  localparam int WORD_W  = 32;
  localparam int BE_W    = 4;
  localparam int COUNT_W = 16;

  localparam logic [CMD_W-1:0] CMD_RESET  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEED   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REFILL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd3;

  localparam logic [WORD_W-1:0] GOLDEN_WORD = 32'h9e37_79b9;

  typedef struct packed {
    logic [4:0] r1;
    logic [4:0] r2;
    logic [4:0] r3;
  } rot_t;

  // rotation amounts of the four sets
  function automatic rot_t rot_select(input logic [1:0] sel);
    rot_t r;
    unique case (sel)
      2'd0: r = '{r1: 5'd17, r2: 5'd3,  r3: 5'd4};
      2'd1: r = '{r1: 5'd15, r2: 5'd18, r3: 5'd23};
      2'd2: r = '{r1: 5'd3,  r2: 5'd23, r3: 5'd24};
      2'd3: r = '{r1: 5'd3,  r2: 5'd15, r3: 5'd8};
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input logic [4:0] k);
    return (x << k) | (x >> (6'd32 - {1'b0, k}));
  endfunction

endpackage

// ----- hdl/irpg_if.sv -----
interface irpg_cmd_if import irpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [INDEX_W-1:0] word_index;
  logic [WORD_W-1:0]  seed_word;
  logic [BE_W-1:0]    byte_enable;
  logic [COUNT_W-1:0] discard_count;

  modport source(output valid, cmd, word_index, seed_word, byte_enable, discard_count,
                 input ready);
  modport sink(input valid, cmd, word_index, seed_word, byte_enable, discard_count,
               output ready);
endinterface

interface irpg_res_if import irpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;
  logic              word_valid;

  modport source(output valid, random_word, word_valid, input ready);
  modport sink(input valid, random_word, word_valid, output ready);
endinterface

// ----- hdl/irpg_ram.sv -----
module irpg_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/irpg_addr_mod.sv -----
module irpg_addr_mod import irpg_pkg::*; #(
  parameter int N  = 512,
  parameter int AW = $clog2(N)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] x,
  output logic              done,
  output logic [AW-1:0]     res
);

  generate
    if ((N & (N - 1)) == 0) begin : g_pow2
      // table size a power of two: the low bits
      assign done = start;
      assign res  = x[AW-1:0];
    end else begin : g_iter
      localparam int RW = AW + 1;

      logic [RW-1:0]     rem;
      logic [WORD_W-1:0] shreg;
      logic [1:0]        cnt;
      logic              busy;
      logic              done_q;

      // eight restoring steps, msb first
      function automatic logic [RW-1:0] step8(input logic [RW-1:0] r_in,
                                              input logic [7:0] bits);
        logic [RW:0]   t;
        logic [RW-1:0] r;
        r = r_in;
        for (int i = 7; i >= 0; i--) begin
          t = {r, bits[i]};
          if (t >= (RW + 1)'(N)) begin
            t = t - (RW + 1)'(N);
          end
          r = t[RW-1:0];
        end
        return r;
      endfunction

      always_ff @(posedge clk) begin
        if (rst) begin
          busy   <= 1'b0;
          done_q <= 1'b0;
          cnt    <= '0;
        end else begin
          done_q <= 1'b0;
          if (start && !busy && !done_q) begin
            busy <= 1'b1;
            cnt  <= '0;
          end else if (busy) begin
            cnt <= cnt + 2'd1;
            if (cnt == 2'd3) begin
              busy   <= 1'b0;
              done_q <= 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start && !busy && !done_q) begin
          shreg <= x;
          rem   <= '0;
        end else if (busy) begin
          shreg <= shreg << 8;
          rem   <= step8(rem, shreg[WORD_W-1 -: 8]);
        end
      end

      assign done = done_q;
      assign res  = rem[AW-1:0];
    end
  endgenerate

endmodule

// ----- hdl/indirect_rotate_prng_generator_core.sv -----
// draw: the buffered word goes through the output register; the next beat waits until the draw is done
// a batch of TABLE_WORDS rounds, each a table read, a mix and an indirect read
// seed write merges one table word; refill runs one batch plus one batch per TABLE_WORDS discards
// rst and the reset command sweep both memories with no beat taken
`include "indirect_rotate_prng_generator_core_defines.svh"

module indirect_rotate_prng_generator_core import irpg_pkg::*; #(
  parameter int TABLE_WORDS = 512
) (
  input  logic       clk,
  input  logic       rst,
  irpg_cmd_if.sink   command,
  irpg_res_if.source result
);

  localparam int AW = $clog2(TABLE_WORDS);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_WORDS - 1);

  // controller states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CLEAR   = 4'd1;
  localparam logic [3:0] ST_SEED_RD = 4'd2;
  localparam logic [3:0] ST_SEED_WR = 4'd3;
  localparam logic [3:0] ST_DRAW    = 4'd4;
  localparam logic [3:0] ST_RA      = 4'd5;
  localparam logic [3:0] ST_MIX     = 4'd6;
  localparam logic [3:0] ST_RB      = 4'd7;
  localparam logic [3:0] ST_FIN     = 4'd8;
  localparam logic [3:0] ST_DISC    = 4'd9;
  localparam logic [3:0] ST_RESP    = 4'd10;

  // control
  logic [3:0]    state;
  logic [AW-1:0] clr;
  logic          clr_reply;
  logic [AW-1:0] ptr;
  logic [1:0]    rot_sel;
  logic [AW-1:0] rnd;
  logic          out_valid;

  // latched command beat
  logic [CMD_W-1:0]   cmd_q;
  logic [INDEX_W-1:0] idx_q;
  logic [WORD_W-1:0]  seed_q;
  logic [BE_W-1:0]    be_q;
  logic [COUNT_W-1:0] rem_q;

  // mixing words and round temporaries
  logic [WORD_W-1:0] mix_b;
  logic [WORD_W-1:0] mix_c;
  logic [WORD_W-1:0] mix_d;
  logic [WORD_W-1:0] e_q;
  logic [AW-1:0]     addr_q;

  // pending and output result
  logic [WORD_W-1:0] res_word;
  logic              res_valid;
  logic [WORD_W-1:0] out_word;
  logic              out_flag;

  // combinational
  logic              accept;
  logic              out_free;
  logic              deliver;
  logic              last_round;
  logic              ptr_last;
  rot_t              rot;
  logic [WORD_W-1:0] fin_sum;
  logic [WORD_W-1:0] be_mask;
  logic [AW:0]       left;
  logic [COUNT_W-1:0] left_cnt;
  logic              disc_wrap;

  // address reduction
  logic              mod_start;
  logic [WORD_W-1:0] mod_x;
  logic              mod_done;
  logic [AW-1:0]     mod_res;

  // memory ports
  logic              t_we;
  logic [AW-1:0]     t_waddr;
  logic [WORD_W-1:0] t_wdata;
  logic [WORD_W-1:0] t_rdata;
  logic              b_we;
  logic [AW-1:0]     b_waddr;
  logic [WORD_W-1:0] b_wdata;
  logic [WORD_W-1:0] b_rdata;

  assign accept        = command.valid && command.ready;
  assign command.ready = (state == ST_IDLE);

  // output register frees the command side from the consumer
  assign out_free           = !out_valid || result.ready;
  assign result.valid       = out_valid;
  assign result.random_word = out_word;
  assign result.word_valid  = out_flag;

  assign last_round = (rnd == LAST_IDX);
  assign ptr_last   = (ptr == LAST_IDX);
  assign rot        = rot_select(rot_sel);

  // next d: e plus the indirectly addressed table word
  assign fin_sum = e_q + t_rdata;

  // draws left before the buffer runs out
  assign left      = (AW + 1)'(TABLE_WORDS) - {1'b0, ptr};
  assign left_cnt  = COUNT_W'(left);
  assign disc_wrap = (rem_q >= left_cnt);

  // a draw that does not wrap goes straight to the output register when it is free
  assign deliver = out_free && ((state == ST_RESP) || (state == ST_DRAW && !ptr_last));

  always_comb begin
    for (int n = 0; n < BE_W; n++) begin
      be_mask[8*n +: 8] = {8{be_q[n]}};
    end
  end

  // one reduction unit serves every table address
  always_comb begin
    case (state)
      ST_RA:      mod_x = mix_d;
      ST_RB:      mod_x = mix_b;
      ST_FIN:     mod_x = fin_sum;
      ST_SEED_RD: mod_x = WORD_W'(idx_q);
      default:    mod_x = mix_d;
    endcase
  end

  assign mod_start = (state == ST_RA) || (state == ST_RB) || (state == ST_SEED_RD) ||
                     (state == ST_FIN && !last_round);

  irpg_addr_mod #(
    .N  (TABLE_WORDS),
    .AW (AW)
  ) u_addr_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .x     (mod_x),
    .done  (mod_done),
    .res   (mod_res)
  );

  // mixing table: clearing sweep, round update, seed merge
  always_comb begin
    t_we    = 1'b0;
    t_waddr = addr_q;
    t_wdata = mix_b ^ rotl32(mix_c, rot.r2);
    case (state)
      ST_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr;
        t_wdata = GOLDEN_WORD;
      end
      ST_MIX: begin
        t_we = 1'b1;
      end
      ST_SEED_WR: begin
        t_we    = 1'b1;
        t_wdata = (t_rdata & ~be_mask) | (seed_q & be_mask);
      end
      default: begin
        t_we = 1'b0;
      end
    endcase
  end

  irpg_ram #(
    .DEPTH (TABLE_WORDS),
    .AW    (AW),
    .DW    (WORD_W)
  ) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (mod_res),
    .rdata (t_rdata)
  );

  // result buffer: clearing sweep and one word per round
  assign b_we    = (state == ST_CLEAR) || (state == ST_FIN);
  assign b_waddr = (state == ST_CLEAR) ? clr : rnd;
  assign b_wdata = (state == ST_CLEAR) ? '0 : fin_sum;

  irpg_ram #(
    .DEPTH (TABLE_WORDS),
    .AW    (AW),
    .DW    (WORD_W)
  ) u_buffer (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (ptr),
    .rdata (b_rdata)
  );

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      clr_reply <= 1'b0;
      ptr       <= '0;
      rot_sel   <= '0;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (command.cmd)
              CMD_RESET: begin
                state     <= ST_CLEAR;
                clr       <= '0;
                clr_reply <= 1'b1;
              end
              CMD_SEED: begin
                state <= ST_SEED_RD;
              end
              CMD_REFILL: begin
                rnd   <= '0;
                state <= ST_RA;
              end
              CMD_DRAW: begin
                state <= ST_DRAW;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == LAST_IDX) begin
            ptr     <= '0;
            rot_sel <= '0;
            state   <= clr_reply ? ST_RESP : ST_IDLE;
          end
        end
        ST_SEED_RD: begin
          if (mod_done) begin
            state <= ST_SEED_WR;
          end
        end
        ST_SEED_WR: begin
          state <= ST_RESP;
        end
        ST_DRAW: begin
          // last buffered word drawn: refill before answering
          if (ptr_last) begin
            rnd   <= '0;
            state <= ST_RA;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= out_free ? ST_IDLE : ST_RESP;
          end
        end
        ST_RA: begin
          if (mod_done) begin
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          state <= ST_RB;
        end
        ST_RB: begin
          if (mod_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (last_round) begin
            rot_sel <= mix_c[1:0];
            ptr     <= '0;
            state   <= (cmd_q == CMD_DRAW) ? ST_RESP : ST_DISC;
          end else begin
            rnd   <= rnd + 1'b1;
            state <= mod_done ? ST_MIX : ST_RA;
          end
        end
        ST_DISC: begin
          // skip to the end of the buffer, or stop inside it
          if (disc_wrap) begin
            rnd   <= '0;
            state <= ST_RA;
          end else begin
            ptr   <= ptr + rem_q[AW-1:0];
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= command.cmd;
      idx_q     <= command.word_index;
      seed_q    <= command.seed_word;
      be_q      <= command.byte_enable;
      rem_q     <= command.discard_count;
      res_word  <= '0;
      res_valid <= (command.cmd == CMD_DRAW);
    end

    if (mod_done) begin
      addr_q <= mod_res;
    end

    case (state)
      ST_CLEAR: begin
        if (clr == LAST_IDX) begin
          mix_b <= GOLDEN_WORD;
          mix_c <= GOLDEN_WORD;
          mix_d <= GOLDEN_WORD;
        end
      end
      ST_DRAW: begin
        res_word <= b_rdata;
      end
      ST_MIX: begin
        e_q   <= t_rdata - rotl32(mix_b, rot.r1);
        mix_b <= mix_c + rotl32(mix_d, rot.r3);
      end
      ST_RB: begin
        mix_c <= mix_d + e_q;
      end
      ST_FIN: begin
        mix_d <= fin_sum;
      end
      ST_DISC: begin
        if (disc_wrap) begin
          rem_q <= rem_q - left_cnt;
        end
      end
      default: begin
        e_q <= e_q;
      end
    endcase

    if (deliver) begin
      out_word <= (state == ST_DRAW) ? b_rdata : res_word;
      out_flag <= (state == ST_DRAW) ? 1'b1 : res_valid;
    end
  end

  `IRPG_ASSERT_IMP(a_ptr_in_table, clk, rst, 1'b1, ptr <= LAST_IDX, "draw pointer past table")
  `IRPG_ASSERT_IMP(a_mod_done_req, clk, rst, mod_done, mod_start, "address ready unrequested")
  `IRPG_ASSERT_NXT(a_busy_after_beat, clk, rst, accept, state != ST_IDLE, "beat left idle")

endmodule

// ----- test/indirect_rotate_prng_generator_core_tb.sv -----
`timescale 1ns / 100ps

module indirect_rotate_prng_generator_core_tb;
  import irpg_pkg::*;

  localparam int TABLE_WORDS  = 512;
  localparam int ADDR_W       = $clog2(TABLE_WORDS);
  localparam int RANDOM_ITEMS = 1300;
  localparam int LONG_PAUSE   = 40;
  // rough cost of one refill batch in the block
  localparam int BATCH_CYCLES = 3 * TABLE_WORDS + 1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] word_index;
    logic [WORD_W-1:0]  seed_word;
    logic [BE_W-1:0]    byte_enable;
    logic [COUNT_W-1:0] discard_count;
  } command_t;

  typedef struct packed {
    logic [WORD_W-1:0] random_word;
    logic              word_valid;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;

  irpg_cmd_if cmd_bus ();
  irpg_res_if res_bus ();

  indirect_rotate_prng_generator_core #(
    .TABLE_WORDS(TABLE_WORDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .command(cmd_bus),
    .result(res_bus)
  );

  // 12 ns period
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // generator state as the testbench sees it
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0] gen_table [TABLE_WORDS];
  logic [WORD_W-1:0] gen_buffer [TABLE_WORDS];
  logic [WORD_W-1:0] gen_b, gen_c, gen_d;
  logic [ADDR_W-1:0] gen_ptr;
  logic [1:0]        gen_rot;

  // stimulus not yet offered, and words the block still owes us
  command_t pending_cmds[$];
  outcome_t expected_words[$];
  command_t in_flight;

  int unsigned beats_sent, results_seen, fault_count;
  int unsigned draws_done, refills_done, seeds_done, resets_done, batches_run;
  longint      cycle_count, cycle_limit, slow_estimate;

  // pause bookkeeping for both sides
  int send_gap, send_calm, stall_left, stall_calm;

  function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] x,
                                                 input int unsigned k);
    int unsigned s;
    s = k % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  // left rotations of the four sets
  function automatic void rotation_triple(input logic [1:0] sel, output int unsigned r1,
                                          output int unsigned r2, output int unsigned r3);
    case (sel)
      2'd0: begin r1 = 17; r2 = 3;  r3 = 4;  end
      2'd1: begin r1 = 15; r2 = 18; r3 = 23; end
      2'd2: begin r1 = 3;  r2 = 23; r3 = 24; end
      default: begin r1 = 3; r2 = 15; r3 = 8; end
    endcase
  endfunction

  function automatic void restore_power_on();
    for (int i = 0; i < TABLE_WORDS; i++) begin
      gen_table[i]  = GOLDEN_WORD;
      gen_buffer[i] = '0;
    end
    gen_b   = GOLDEN_WORD;
    gen_c   = GOLDEN_WORD;
    gen_d   = GOLDEN_WORD;
    gen_ptr = '0;
    gen_rot = '0;
  endfunction

  // one batch: indirect table lookup through b, rewrite of the entry at d
  function automatic void refill_buffer();
    int unsigned       r1, r2, r3;
    logic [WORD_W-1:0] e;
    rotation_triple(gen_rot, r1, r2, r3);
    for (int i = 0; i < TABLE_WORDS; i++) begin
      e = gen_table[gen_d[ADDR_W-1:0]] - rot_left(gen_b, r1);
      gen_table[gen_d[ADDR_W-1:0]] = gen_b ^ rot_left(gen_c, r2);
      gen_b = gen_c + rot_left(gen_d, r3);
      gen_c = gen_d + e;
      gen_d = e + gen_table[gen_b[ADDR_W-1:0]];
      gen_buffer[i] = gen_d;
    end
    gen_rot = gen_c[1:0];
    batches_run++;
  endfunction

  // hand out the next buffered word, batching again after the last one
  function automatic logic [WORD_W-1:0] next_word();
    logic [WORD_W-1:0] w;
    w = gen_buffer[gen_ptr];
    if (gen_ptr == ADDR_W'(TABLE_WORDS - 1)) begin
      refill_buffer();
      gen_ptr = '0;
    end else begin
      gen_ptr = gen_ptr + 1'b1;
    end
    return w;
  endfunction

  function automatic outcome_t command_outcome(input command_t c);
    outcome_t          o;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] w;
    o = '0;
    case (c.cmd)
      CMD_RESET: begin
        restore_power_on();
        resets_done++;
      end
      CMD_SEED: begin
        mask = '0;
        for (int n = 0; n < BE_W; n++)
          if (c.byte_enable[n]) mask[8*n +: 8] = 8'hff;
        gen_table[c.word_index[ADDR_W-1:0]] =
          (gen_table[c.word_index[ADDR_W-1:0]] & ~mask) | (c.seed_word & mask);
        seeds_done++;
      end
      CMD_REFILL: begin
        // pointer goes back to zero before the discards start
        refill_buffer();
        gen_ptr = '0;
        for (int k = 0; k < int'(c.discard_count); k++) w = next_word();
        refills_done++;
      end
      default: begin
        o.random_word = next_word();
        o.word_valid  = 1'b1;
        draws_done++;
      end
    endcase
    return o;
  endfunction

  // mostly no pause, some short ones, a few long ones, and now and then a calm stretch of none
  function automatic int pick_pause(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, LONG_PAUSE);
  endfunction

  // adds a command and grows the worst-case cycle estimate with it
  function automatic void queue_item(input logic [CMD_W-1:0] op,
                                     input logic [INDEX_W-1:0] idx,
                                     input logic [WORD_W-1:0] seed,
                                     input logic [BE_W-1:0] be,
                                     input logic [COUNT_W-1:0] cnt);
    command_t c;
    c = '{cmd: op, word_index: idx, seed_word: seed, byte_enable: be, discard_count: cnt};
    pending_cmds.push_back(c);
    slow_estimate += 2 * LONG_PAUSE + 20;
    case (op)
      CMD_RESET:  slow_estimate += TABLE_WORDS + 8;
      CMD_REFILL: slow_estimate += longint'(2 + cnt / TABLE_WORDS) * BATCH_CYCLES + 6 * cnt;
      CMD_DRAW:   slow_estimate += 12;
      default:    slow_estimate += 4;
    endcase
  endfunction

  function automatic void queue_random(input logic [CMD_W-1:0] op,
                                       input logic [COUNT_W-1:0] cnt);
    queue_item(op, INDEX_W'($urandom_range(0, TABLE_WORDS - 1)), $urandom(),
               BE_W'($urandom_range(0, 15)), cnt);
  endfunction

  // discards: many small, many around a batch boundary, a few up to 4095
  function automatic logic [COUNT_W-1:0] pick_discard();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return COUNT_W'($urandom_range(0, 20));
    if (roll < 65) return COUNT_W'($urandom_range(TABLE_WORDS - 12, TABLE_WORDS + 12));
    if (roll < 90) return COUNT_W'($urandom_range(21, 1500));
    return COUNT_W'($urandom_range(0, 4095));
  endfunction

  // draw runs: mostly short, some long enough to run past the buffer end
  function automatic int pick_run();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 40);
    if (roll < 90) return $urandom_range(41, 150);
    return $urandom_range(TABLE_WORDS - 12, TABLE_WORDS + 20);
  endfunction

  // ---------------------------------------------------------------------
  // command driver: predicts at the accepting edge, then offers the next beat
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        expected_words.push_back(command_outcome(in_flight));
        beats_sent++;
        send_gap = pick_pause(send_calm);
      end
      if (cmd_bus.valid && !cmd_bus.ready) begin
        // beat still on offer, hold it
      end else if (send_gap > 0) begin
        send_gap--;
        cmd_bus.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_flight = pending_cmds.pop_front();
        cmd_bus.valid         <= 1'b1;
        cmd_bus.cmd           <= in_flight.cmd;
        cmd_bus.word_index    <= in_flight.word_index;
        cmd_bus.seed_word     <= in_flight.seed_word;
        cmd_bus.byte_enable   <= in_flight.byte_enable;
        cmd_bus.discard_count <= in_flight.discard_count;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result monitor: compares each accepted beat with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("unexpected result beat %0d: word %h valid %b", results_seen,
                     res_bus.random_word, res_bus.word_valid);
        end else begin
          want = expected_words.pop_front();
          if (res_bus.random_word !== want.random_word ||
              res_bus.word_valid !== want.word_valid) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display("mismatch on result %0d: word exp %h got %h, valid exp %b got %b",
                       results_seen, want.random_word, res_bus.random_word,
                       want.word_valid, res_bus.word_valid);
          end
        end
      end
      // receiver back-pressure
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
        stall_left = pick_pause(stall_calm);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("run stopped at cycle limit %0d with %0d results outstanding", cycle_limit,
               expected_words.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int roll;
    int run;
    int directed;

    rst                   = 1'b1;
    cmd_bus.valid         = 1'b0;
    cmd_bus.cmd           = CMD_RESET;
    cmd_bus.word_index    = '0;
    cmd_bus.seed_word     = '0;
    cmd_bus.byte_enable   = '0;
    cmd_bus.discard_count = '0;
    res_bus.ready         = 1'b0;
    send_gap              = 0;
    send_calm             = 0;
    stall_left            = 0;
    stall_calm            = 0;
    cycle_count           = 0;
    slow_estimate         = 0;
    restore_power_on();

    // directed: draw from the untouched buffer, seed byte lanes, pointer edges
    queue_item(CMD_DRAW, '0, '0, '0, '0);
    queue_item(CMD_SEED, '0, 32'hffff_ffff, 4'hf, 16'hffff);
    queue_item(CMD_SEED, 9'd511, 32'h1234_5678, 4'h0, '0);      // no lanes enabled
    queue_item(CMD_SEED, 9'd511, 32'ha5a5_a5a5, 4'h5, '0);
    queue_item(CMD_SEED, 9'd256, 32'h0000_0000, 4'ha, '0);
    queue_item(CMD_REFILL, '0, '0, '0, 16'd0);
    queue_item(CMD_DRAW, 9'd511, 32'hffff_ffff, 4'hf, 16'hffff);
    queue_item(CMD_DRAW, '0, '0, '0, '0);
    // leaves the pointer on the last word, the next draw starts a batch
    queue_item(CMD_REFILL, '0, '0, '0, COUNT_W'(TABLE_WORDS - 1));
    queue_item(CMD_DRAW, '0, '0, '0, '0);
    queue_item(CMD_DRAW, '0, '0, '0, '0);
    // discards running exactly across one batch, then the largest count
    queue_item(CMD_REFILL, '0, '0, '0, COUNT_W'(TABLE_WORDS));
    queue_item(CMD_DRAW, '0, '0, '0, '0);
    queue_item(CMD_REFILL, '0, '0, '0, 16'hffff);
    queue_item(CMD_DRAW, '0, '0, '0, '0);
    // full seeding sequence from a reset
    queue_item(CMD_RESET, 9'h1aa, 32'h5a5a_5a5a, 4'h6, 16'h5555);
    queue_item(CMD_DRAW, '0, '0, '0, '0);
    queue_item(CMD_SEED, 9'd3, 32'h0000_00ff, 4'h1, '0);
    queue_item(CMD_SEED, 9'd511, 32'hffff_ffff, 4'hf, '0);
    queue_item(CMD_REFILL, '0, '0, '0, 16'd1);
    queue_item(CMD_DRAW, '0, '0, '0, '0);
    // refill straight after reset with no seed
    queue_item(CMD_RESET, '0, '0, '0, '0);
    queue_item(CMD_REFILL, '0, '0, '0, 16'd2);
    queue_item(CMD_DRAW, '0, '0, '0, '0);
    directed = pending_cmds.size();

    // random: mostly seeding sequences followed by draw runs, some noise
    while (pending_cmds.size() < directed + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        run = $urandom_range(1, 4);
        repeat (run) queue_random(CMD_W'($urandom_range(0, 3)),
                                  COUNT_W'($urandom_range(0, 700)));
      end else if (roll < 20) begin
        // broken sequence: seeds without a refill, drawing the old buffer
        queue_random(CMD_RESET, COUNT_W'($urandom()));
        run = $urandom_range(0, 6);
        repeat (run) queue_random(CMD_SEED, COUNT_W'($urandom()));
        run = $urandom_range(1, 20);
        repeat (run) queue_random(CMD_DRAW, COUNT_W'($urandom()));
      end else begin
        if ($urandom_range(0, 1)) queue_random(CMD_RESET, COUNT_W'($urandom()));
        run = $urandom_range(0, 10);
        repeat (run) queue_random(CMD_SEED, COUNT_W'($urandom()));
        queue_random(CMD_REFILL, pick_discard());
        run = pick_run();
        repeat (run) queue_random(CMD_DRAW, COUNT_W'($urandom()));
      end
    end

    cycle_limit = 4 * slow_estimate + 20 * BATCH_CYCLES + TABLE_WORDS;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // let everything go in, then come back
    while (pending_cmds.size() != 0 || cmd_bus.valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    // room for a stray beat, e.g. one raised after a trailing batch
    repeat (BATCH_CYCLES + 16) @(posedge clk);

    $display("covered %0d resets, %0d seed writes, %0d refills, %0d draws, %0d batches",
             resets_done, seeds_done, refills_done, draws_done, batches_run);
    $display("%0d command beats sent, %0d result beats checked, %0d faults",
             beats_sent, results_seen, fault_count);
    if (fault_count == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/irpg_pkg.sv
hdl/irpg_if.sv
hdl/irpg_ram.sv
hdl/irpg_addr_mod.sv
hdl/indirect_rotate_prng_generator_core.sv
test/indirect_rotate_prng_generator_core_tb.sv
